### rtl/raw_pkg.sv
// shared widths, command and status types for the rolling average block
package raw_pkg;

   localparam int TEMP_W     = 12;
   localparam int AVG_W      = 16;
   localparam int COUNT_W    = 5;
   localparam int FRAC_SHIFT = 4;

   typedef struct packed {
      logic capture;
      logic ring_read;
      logic update;
      logic div_setup;
      logic div_step;
      logic finish;
      logic load_out;
   } raw_cmd_type;

   typedef struct packed {
      logic div_done;
   } raw_status_type;

endpackage

### rtl/raw_req_if.sv
// sample channel: valid/ready handshake with sensor payload
interface raw_req_if import raw_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     sample_valid;
   logic signed [TEMP_W-1:0] temperature;

   modport source (output valid, sample_valid, temperature, input ready);
   modport sink   (input valid, sample_valid, temperature, output ready);
endinterface

### rtl/raw_rsp_if.sv
// result channel: valid/ready handshake with average and count
interface raw_rsp_if import raw_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [AVG_W-1:0]  average;
   logic [COUNT_W-1:0]       sample_count;

   modport source (output valid, average, sample_count, input ready);
   modport sink   (input valid, average, sample_count, output ready);
endinterface

### rtl/raw_ctrl.sv
// sequencing state machine for the rolling average block
module raw_ctrl import raw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_sample_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output raw_cmd_type    cmd,
   input  raw_status_type status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_SETUP  = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               // a missing sample just repeats the last result
               state_in = req_sample_valid ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            cmd.ring_read = 1'b1;
            state_in      = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.div_setup = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/raw_dpath.sv
// sample ring, running sum, serial divider and result registers
module raw_dpath import raw_pkg::*; #(
   parameter int WINDOW = 30
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [TEMP_W-1:0] req_temperature,
   input  raw_cmd_type              cmd,
   output raw_status_type           status,
   output logic signed [AVG_W-1:0]  rsp_average,
   output logic [COUNT_W-1:0]       rsp_sample_count
);

   localparam int IDX_W  = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = TEMP_W + $clog2(WINDOW);
   localparam int DVD_W  = SUM_W + FRAC_SHIFT;
   localparam int ITER_W = $clog2(DVD_W);

   logic signed [TEMP_W-1:0] ring_mem [WINDOW];

   logic signed [TEMP_W-1:0] temp_ff;
   logic signed [TEMP_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]         slot_ff;
   logic                     full_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         count_ff;
   logic                     neg_ff;
   logic [DVD_W-1:0]         dvd_ff;
   logic [CNT_W-1:0]         rem_ff;
   logic [ITER_W-1:0]        iter_ff;
   logic signed [AVG_W-1:0]  last_avg_ff, avg_in;
   logic [COUNT_W-1:0]       last_count_ff;
   logic signed [AVG_W-1:0]  out_avg_ff;
   logic [COUNT_W-1:0]       out_count_ff;

   logic [SUM_W-1:0]         sum_mag;
   logic [CNT_W+1:0]         trial;
   logic                     q_bit;
   logic [AVG_W-1:0]         q_low;

   // oldest entry leaves the sum only once the ring has wrapped
   always_comb begin
      if (full_ff) begin
         sum_in = sum_ff - SUM_W'(rd_data_ff) + SUM_W'(temp_ff);
      end else begin
         sum_in = sum_ff + SUM_W'(temp_ff);
      end
   end

   assign sum_mag = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;

   // restoring step, one quotient bit per cycle
   assign trial = {1'b0, rem_ff, dvd_ff[DVD_W-1]} - {2'b00, count_ff};
   assign q_bit = ~trial[CNT_W+1];

   // floor for negative sums: -q - (rem != 0) == ~q + (rem == 0)
   assign q_low = dvd_ff[AVG_W-1:0];
   always_comb begin
      if (neg_ff) begin
         avg_in = ~q_low + AVG_W'(rem_ff == '0);
      end else begin
         avg_in = q_low;
      end
   end

   assign status.div_done = (iter_ff == ITER_W'(DVD_W - 1));

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring_mem[slot_ff] <= temp_ff;
      end
      if (cmd.ring_read) begin
         rd_data_ff <= ring_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         temp_ff <= req_temperature;
      end
      if (cmd.div_setup) begin
         neg_ff  <= sum_ff[SUM_W-1];
         dvd_ff  <= {sum_mag, FRAC_SHIFT'(0)};
         rem_ff  <= '0;
         iter_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= {dvd_ff[DVD_W-2:0], q_bit};
         rem_ff  <= q_bit ? trial[CNT_W-1:0] : {rem_ff[CNT_W-2:0], dvd_ff[DVD_W-1]};
         iter_ff <= iter_ff + ITER_W'(1);
      end
      if (cmd.load_out) begin
         out_avg_ff   <= last_avg_ff;
         out_count_ff <= last_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= '0;
         full_ff       <= 1'b0;
         sum_ff        <= '0;
         count_ff      <= '0;
         last_avg_ff   <= '0;
         last_count_ff <= '0;
      end else begin
         if (cmd.update) begin
            sum_ff   <= sum_in;
            count_ff <= full_ff ? CNT_W'(WINDOW) : CNT_W'(slot_ff) + CNT_W'(1);
            if (slot_ff == IDX_W'(WINDOW - 1)) begin
               slot_ff <= '0;
               full_ff <= 1'b1;
            end else begin
               slot_ff <= slot_ff + IDX_W'(1);
            end
         end
         if (cmd.finish) begin
            last_avg_ff   <= avg_in;
            last_count_ff <= COUNT_W'(count_ff);
         end
      end
   end

   assign rsp_average      = out_avg_ff;
   assign rsp_sample_count = out_count_ff;

endmodule

### rtl/rolling_average_warmup.sv
// Rolling average of temperature samples over a ring of WINDOW entries.
// A valid sample replaces the oldest ring entry, updates the running sum and
// yields floor(sum*16/count) in units of 1/16 sample LSB with the sample count; a
// missing sample repeats the previous result (zero before the first sample).
// A valid sample keeps the input side busy from accept through ring read, sum
// update, divider setup, the restoring divider producing one quotient bit per
// cycle, finish and output load; a missing sample goes from capture straight
// to output load. The result register lets the next beat be accepted while the
// previous result is still waiting on the output. No clearing pass after reset.
module rolling_average_warmup import raw_pkg::*; #(
   parameter int WINDOW = 30
) (
   input  logic       clock,
   input  logic       reset,
   raw_req_if.sink    req_chan,
   raw_rsp_if.source  rsp_chan
);

   raw_cmd_type    cmd;
   raw_status_type status;

   raw_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_sample_valid (req_chan.sample_valid),
      .req_ready        (req_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .cmd              (cmd),
      .status           (status)
   );

   raw_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_temperature  (req_chan.temperature),
      .cmd              (cmd),
      .status           (status),
      .rsp_average      (rsp_chan.average),
      .rsp_sample_count (rsp_chan.sample_count)
   );

endmodule

### rtl/raw_checker.sv
// port-level assertions for the rolling average block, bound to the top level
module raw_checker import raw_pkg::*; #(
   parameter int WINDOW = 30
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [AVG_W-1:0]  rsp_average,
   input logic [COUNT_W-1:0]       rsp_sample_count
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average)
         && $stable(rsp_sample_count))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // one sample in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted again before the sample was processed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (WINDOW == 32) || (int'(rsp_sample_count) <= WINDOW))
      else $error("sample count beyond window");

endmodule

bind rolling_average_warmup raw_checker #(
   .WINDOW (WINDOW)
) u_raw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_average      (rsp_chan.average),
   .rsp_sample_count (rsp_chan.sample_count)
);
